// ===== hdl/spisbs_pkg.sv =====
// Shared types and codes for the SPI slave byte shifter.
package spisbs_pkg;

	// Register access or pin sample, carried on the input tuser
	localparam logic [1:0] OP_PIN_SAMPLE = 2'd0;
	localparam logic [1:0] OP_WRITE_TX   = 2'd1;
	localparam logic [1:0] OP_READ_RX    = 2'd2;
	localparam logic [1:0] OP_READ_STAT  = 2'd3;

	// Bits of the enable_mode register
	localparam int MODE_RX_BIT = 0;
	localparam int MODE_TX_BIT = 1;

	// Status flags, rx_ready in the lowest bit
	typedef struct packed {
		logic underrun;
		logic overrun;
		logic shift_done;
		logic tx_empty;
		logic rx_ready;
	} flags_t;

	localparam flags_t FLAGS_RESET = '{underrun: 1'b0, overrun: 1'b0, shift_done: 1'b0,
		tx_empty: 1'b1, rx_ready: 1'b0};

	// One result item, miso_level in the lowest bit
	typedef struct packed {
		logic       tx_event;
		logic       rx_event;
		flags_t     flags;
		logic [7:0] read_byte;
		logic       miso_level;
	} result_t;

endpackage

// ===== hdl/spisbs_core.sv =====
// State registers and per-item update logic of the SPI slave byte shifter.
module spisbs_core #(
	parameter int FRAME_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata,
	input  logic                item_valid,
	input  logic [1:0]          operation,
	input  logic                select_level,
	input  logic                clock_level,
	input  logic                mosi_level,
	input  logic [7:0]          write_byte,
	output spisbs_pkg::result_t result
);

	localparam int SW = FRAME_BITS + 1;
	localparam int BW = $clog2(FRAME_BITS + 1);
	localparam logic [BW-1:0] FRAME_CNT = BW'(FRAME_BITS);

	logic [1:0]         mode_q;
	logic [SW-1:0]      shifter_q, shifter_n;
	logic [BW-1:0]      bits_q, bits_n;
	logic [7:0]         tx_q, tx_n;
	logic [7:0]         rx_q, rx_n;
	spisbs_pkg::flags_t flags_q, flags_n;
	logic [1:0]         pins_q, pins_n;
	logic               miso_q, miso_n;
	logic               fall_q, fall_n;
	logic [7:0]         rbyte;
	logic               rx_ev, tx_ev;
	logic               clock_ok;

	// Compute next state and the result of the current item
	always_comb begin
		shifter_n = shifter_q;
		bits_n    = bits_q;
		tx_n      = tx_q;
		rx_n      = rx_q;
		flags_n   = flags_q;
		pins_n    = pins_q;
		miso_n    = miso_q;
		fall_n    = fall_q;
		rbyte     = '0;
		rx_ev     = 1'b0;
		tx_ev     = 1'b0;
		clock_ok  = 1'b1;
		unique case (operation)
			spisbs_pkg::OP_PIN_SAMPLE: begin
				// Select edges first
				if (pins_q[0] && !select_level) begin
					fall_n = 1'b0;
					bits_n = '0;
					if (mode_q != 2'b00) begin
						bits_n = FRAME_CNT;
						if (mode_q[spisbs_pkg::MODE_TX_BIT]) begin
							if (flags_n.tx_empty) begin
								flags_n.underrun = 1'b1;
							end else begin
								shifter_n        = SW'(tx_q);
								flags_n.tx_empty = 1'b1;
								tx_ev            = 1'b1;
							end
						end
					end
				end else if (!pins_q[0] && select_level) begin
					bits_n   = '0;
					fall_n   = 1'b0;
					clock_ok = 1'b0;
				end
				// Clock edges inside a frame
				if (clock_ok && !select_level) begin
					if (!pins_q[1] && clock_level && bits_n != '0) begin
						bits_n    = bits_n - 1'b1;
						shifter_n = {shifter_n[SW-2:0], 1'b0};
						fall_n    = 1'b1;
						if (mode_q[spisbs_pkg::MODE_RX_BIT]) begin
							shifter_n[0] = mosi_level;
							if (bits_n == '0) begin
								rx_n = 8'(shifter_n);
								if (flags_n.rx_ready) begin
									flags_n.overrun = 1'b1;
								end else begin
									flags_n.rx_ready = 1'b1;
								end
								rx_ev = 1'b1;
							end
						end
					end else if (pins_q[1] && !clock_level && fall_n) begin
						fall_n = 1'b0;
						if (mode_q[spisbs_pkg::MODE_TX_BIT]) begin
							miso_n = shifter_n[SW-1];
							if (bits_n == '0) begin
								flags_n.shift_done = 1'b1;
							end
						end
					end
				end
				pins_n = {clock_level, select_level};
			end
			spisbs_pkg::OP_WRITE_TX: begin
				tx_n               = write_byte;
				flags_n.tx_empty   = 1'b0;
				flags_n.shift_done = 1'b0;
			end
			spisbs_pkg::OP_READ_RX: begin
				rbyte            = rx_q;
				flags_n.rx_ready = 1'b0;
			end
			spisbs_pkg::OP_READ_STAT: begin
				rbyte            = {3'b000, flags_q};
				flags_n.overrun  = 1'b0;
				flags_n.underrun = 1'b0;
			end
			default: begin
				rbyte = '0;
			end
		endcase
	end

	// Pack the result of this item
	assign result = '{tx_event: tx_ev, rx_event: rx_ev, flags: flags_n,
		read_byte: rbyte, miso_level: miso_n};

	// Hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'b00;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Advance state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shifter_q <= '0;
			bits_q    <= '0;
			tx_q      <= '0;
			rx_q      <= '0;
			flags_q   <= spisbs_pkg::FLAGS_RESET;
			pins_q    <= 2'b01;
			miso_q    <= 1'b0;
			fall_q    <= 1'b0;
		end else if (item_valid) begin
			shifter_q <= shifter_n;
			bits_q    <= bits_n;
			tx_q      <= tx_n;
			rx_q      <= rx_n;
			flags_q   <= flags_n;
			pins_q    <= pins_n;
			miso_q    <= miso_n;
			fall_q    <= fall_n;
		end
	end

	// Bit count never exceeds a frame
	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= FRAME_CNT)
		else $error("bit count beyond frame length");

	// A pending falling edge means at least one bit was shifted
	a_fall_after_rise: assert property (@(posedge clk) disable iff (!arst_n)
		fall_q |-> (bits_q < FRAME_CNT))
		else $error("falling edge pending without a rising edge");

	// Load and store never happen on the same item
	a_events_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid |-> !(rx_ev && tx_ev))
		else $error("load and store in one item");

	// A load leaves the transmit register empty
	a_load_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && tx_ev) |=> flags_q.tx_empty)
		else $error("transmit register not empty after load");

	// A stored byte leaves rx_ready set
	a_store_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && rx_ev) |=> flags_q.rx_ready)
		else $error("rx_ready not set after store");

endmodule

// ===== hdl/spisbs_outreg.sv =====
// Output register that holds one result until the receiver takes it.
module spisbs_outreg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spisbs_pkg::result_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output spisbs_pkg::result_t out_data
);

	logic                valid_q;
	spisbs_pkg::result_t data_q;

	// Take a new result whenever the slot is free or drains this cycle
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Hold valid until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Capture the payload on load
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= in_data;
		end
	end

endmodule

// ===== hdl/spi_slave_byte_shifter.sv =====
// Top level of the SPI slave byte shifter.
// Use: feed one item per transfer on the s_ side. s_tuser carries the
// operation: a pin sample (select, clock, MOSI levels), a transmit data
// write, a received data read or a status read. Pin samples are edge
// detected against the previous pin sample, so send them at a steady rate.
// Each item yields exactly one result on the m_ side: MISO level, read
// byte, the five status flags and the load/store event pulses.
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one item per cycle unless m_tready stalls; the whole update is
// one pass of logic between the state registers and the output register.
// cfg_we writes enable_mode (bit0 receive, bit1 transmit) at the clock edge;
// write it only while no item is in flight.
// Reset: shifter, holding registers and MISO clear, only tx_reg_empty is
// set, select is taken as high and clock as low, the mode is disabled.
// Stall: while m_tready is low a held result blocks new input; s_tready
// follows the output slot, so input resumes in the cycle the result drains.
module spi_slave_byte_shifter #(
	parameter int FRAME_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] select_level, [1] clock_level, [2] mosi_level, [10:3] write_byte, rest zero
	input  logic [15:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] miso_level, [8:1] read_byte, [9] rx_ready, [10] tx_reg_empty,
	// [11] shift_done, [12] overrun, [13] underrun, [14] rx_event, [15] tx_event
	output logic [15:0] m_tdata
);

	spisbs_pkg::result_t core_res;
	spisbs_pkg::result_t out_res;
	logic                accept;

	assign accept = s_tvalid && s_tready;

	// Update state for each accepted item
	spisbs_core #(
		.FRAME_BITS (FRAME_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (accept),
		.operation    (s_tuser),
		.select_level (s_tdata[0]),
		.clock_level  (s_tdata[1]),
		.mosi_level   (s_tdata[2]),
		.write_byte   (s_tdata[10:3]),
		.result       (core_res)
	);

	// Hold the result for the receiver
	spisbs_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (core_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = out_res;

endmodule
